/* sv/sitr_pkg.sv */
package sitr_pkg;

  // Input beat: value to convert and the radix.
  typedef struct packed {
    logic signed [63:0] value;
    logic [5:0]         radix;
  } in_t;

  // Result beat: one ASCII character.
  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } out_t;

  // Classification handed from front to back through the queue.
  typedef struct packed {
    logic       neg;
    logic [5:0] radix;
  } ctl_t;

  localparam logic [5:0] RADIX_MIN  = 6'd3;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_NINE    = 7'h39;
  localparam logic [6:0] LETTER_GAP = 7'd39;
  localparam logic [6:0] CH_MINUS   = 7'h2d;

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] c;
    c = CH_ZERO + {1'b0, d};
    if (c > CH_NINE) begin
      c = c + LETTER_GAP;
    end
    return c;
  endfunction

endpackage

/* sv/signed_integer_to_radix_text.sv */
// Signed integer to radix text.
// Input: drive in_data (value, radix) and raise start; the beat is taken at
// an edge where start is high and busy is low. Only the low VALUE_BITS bits
// of value count, read as two's complement. Radix below 3 acts as 3, above
// 36 as 36.
// Output: one ASCII character per beat, most significant first, each shown
// for exactly one cycle with out_valid high. A negative value opens with '-'.
// last_char marks the final character of each string. The receiver cannot
// stall; characters simply stream out as they are ready.
// Conversion: the back end divides the magnitude by the radix one byte of
// dividend per cycle, taking one pass over all bytes of the dividend for
// each digit. All digits are found first, then read back from the digit
// buffer one character at a time, after the '-' of a negative value.
// A two-entry queue between front and back takes new items while the back
// end works; busy is high only while that queue is full.
// Reset (synchronous, rst_n low) empties the queue and idles the back end.
module signed_integer_to_radix_text #(
  parameter int VALUE_BITS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sitr_pkg::in_t   in_data,
  output logic            out_valid,
  output sitr_pkg::out_t  out_data
);
  import sitr_pkg::*;

  localparam int ENTRY_W = $bits(ctl_t) + VALUE_BITS;

  // Front: handshake, radix clamp, sign and magnitude.
  logic                  push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  ctl_t                  f_ctl;
  logic [VALUE_BITS-1:0] f_mag;
  ctl_t                  b_ctl;
  logic [VALUE_BITS-1:0] b_mag;
  logic [ENTRY_W-1:0]    q_dout;

  sitr_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_data (in_data),
    .start   (start),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .ctl     (f_ctl),
    .mag     (f_mag)
  );

  // Queue decouples accept from the long divide loop.
  sitr_fifo #(
    .DATA_W(ENTRY_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({f_ctl, f_mag}),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_ctl = q_dout[ENTRY_W-1 -: $bits(ctl_t)];
  assign b_mag = q_dout[VALUE_BITS-1:0];

  // Back: digit extraction into the buffer, then readout MSB first.
  sitr_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_ctl     (b_ctl),
    .q_mag     (b_mag),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sv/sitr_front.sv */
module sitr_front #(
  parameter int VALUE_BITS = 64
) (
  input  sitr_pkg::in_t           in_data,
  input  logic                    start,
  input  logic                    q_full,
  output logic                    busy,
  output logic                    push,
  output sitr_pkg::ctl_t          ctl,
  output logic [VALUE_BITS-1:0]   mag
);
  import sitr_pkg::*;

  logic [VALUE_BITS-1:0] v;

  assign busy = q_full;
  assign push = start && !q_full;
  assign v    = in_data.value[VALUE_BITS-1:0];

  always_comb begin
    ctl.neg = v[VALUE_BITS-1];
    if (in_data.radix inside {[6'd0:6'd2]}) begin
      ctl.radix = RADIX_MIN;
    end else if (in_data.radix inside {[6'd37:6'd63]}) begin
      ctl.radix = RADIX_MAX;
    end else begin
      ctl.radix = in_data.radix;
    end
    // Most negative value negates to itself: read unsigned it is 2^(N-1).
    mag = ctl.neg ? (~v + 1'b1) : v;
  end

endmodule

/* sv/sitr_fifo.sv */
module sitr_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              full,
  output logic              empty
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* sv/sitr_back.sv */
module sitr_back #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  sitr_pkg::ctl_t        q_ctl,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  q_pop,
  output logic                  out_valid,
  output sitr_pkg::out_t        out_data
);
  import sitr_pkg::*;

  localparam int NCHUNK = (VALUE_BITS + 7) / 8;
  localparam int PAD_W  = NCHUNK * 8;
  localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IDX_W  = $clog2(VALUE_BITS);
  localparam int ND_W   = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_SIGN,
    B_RD,
    B_OUT
  } state_t;

  state_t           state_r;
  logic [PAD_W-1:0] q_r;
  logic [5:0]       rem_r;
  logic [5:0]       radix_r;
  logic             neg_r;
  logic [CNT_W-1:0] chunk_r;
  logic [ND_W-1:0]  nd_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [5:0]       rd_data_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic [5:0]       digit_mem [VALUE_BITS];

  logic [PAD_W-1:0] q_nxt;
  logic [5:0]       rem_nxt;
  logic             last_chunk;
  logic             dig_wr;

  // Eight restoring steps per cycle: one byte of the dividend.
  always_comb begin
    logic [6:0] t;
    logic [5:0] rv;
    logic [7:0] qb;
    rv = rem_r;
    qb = '0;
    for (int i = 0; i < 8; i++) begin
      t = {rv, q_r[PAD_W-1-i]};
      if (t >= {1'b0, radix_r}) begin
        t         = t - {1'b0, radix_r};
        qb[7-i]   = 1'b1;
      end
      rv = t[5:0];
    end
    rem_nxt = rv;
    q_nxt   = (q_r << 8) | PAD_W'(qb);
  end

  assign last_chunk = (chunk_r == CNT_W'(NCHUNK - 1));
  assign dig_wr     = (state_r == B_DIV) && last_chunk;
  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (dig_wr) begin
      digit_mem[nd_r[IDX_W-1:0]] <= rem_nxt;
    end
    if (state_r == B_RD) begin
      rd_data_r <= digit_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            q_r     <= PAD_W'(q_mag);
            radix_r <= q_ctl.radix;
            neg_r   <= q_ctl.neg;
            rem_r   <= '0;
            chunk_r <= '0;
            nd_r    <= '0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          q_r <= q_nxt;
          if (last_chunk) begin
            rem_r   <= '0;
            chunk_r <= '0;
            nd_r    <= nd_r + 1'b1;
            if (q_nxt == '0) begin
              rd_idx_r <= nd_r[IDX_W-1:0];
              state_r  <= neg_r ? B_SIGN : B_RD;
            end
          end else begin
            rem_r   <= rem_nxt;
            chunk_r <= chunk_r + 1'b1;
          end
        end
        B_SIGN: begin
          out_valid_r          <= 1'b1;
          out_data_r.text_char <= CH_MINUS;
          out_data_r.last_char <= 1'b0;
          state_r              <= B_RD;
        end
        B_RD: begin
          state_r <= B_OUT;
        end
        B_OUT: begin
          out_valid_r          <= 1'b1;
          out_data_r.text_char <= digit_char(rd_data_r);
          out_data_r.last_char <= (rd_idx_r == '0);
          if (rd_idx_r == '0) begin
            state_r <= B_IDLE;
          end else begin
            rd_idx_r <= rd_idx_r - 1'b1;
            state_r  <= B_RD;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule
